>>> design/ket_pkg.sv
// ----------------------------------------------------------------------------
// ket_pkg
// Shared types, constants and the control store for the key entry table.
// ----------------------------------------------------------------------------
`default_nettype none

package ket_pkg;

	// Table geometry.
	localparam int TABLE_ENTRIES = 64;
	localparam int ID_BITS       = 64;
	localparam int PAYLOAD_BITS  = 64;
	localparam int IDX_W         = $clog2(TABLE_ENTRIES);
	localparam int CNT_W         = IDX_W + 1;
	localparam int WORD_W        = 2 * ID_BITS + PAYLOAD_BITS;

	// Configuration register.
	localparam int            CFG_W         = 7;
	localparam logic [CFG_W-1:0] ENTRIES_RESET = 7'd64;

	// Transaction modes.
	localparam logic MODE_WRITE = 1'b0;
	localparam logic MODE_READ  = 1'b1;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_NOT_FOUND = 2'd2
	} status_t;

	// Input transaction.
	typedef struct packed {
		logic        mode;
		logic [63:0] client_id;
		logic [63:0] server_id;
		logic [63:0] key_payload;
	} in_item_t;

	// Result transaction.
	typedef struct packed {
		status_t     status;
		logic [5:0]  entry_index;
		logic [63:0] key_payload_out;
	} out_item_t;

	// Microprogram addresses.
	typedef logic [1:0] upc_t;
	localparam upc_t STEP_IDLE   = 2'd0;
	localparam upc_t STEP_SCAN   = 2'd1;
	localparam upc_t STEP_WAIT   = 2'd2;
	localparam upc_t STEP_COMMIT = 2'd3;

	// Jump conditions: when true the sequencer jumps, otherwise it steps on.
	typedef enum logic [1:0] {
		JC_ALWAYS    = 2'd0,
		JC_NO_TAKE   = 2'd1,
		JC_SCAN_BUSY = 2'd2,
		JC_OUT_BUSY  = 2'd3
	} jcond_t;

	// Datapath controls carried by one control word.
	typedef struct packed {
		logic idle;
		logic scan;
		logic commit;
	} ctrl_t;

	// Status from the datapath to the sequencer.
	typedef struct packed {
		logic in_valid;
		logic scan_busy;
		logic out_busy;
	} cond_t;

	// One control word.
	typedef struct packed {
		jcond_t jc;
		upc_t   target;
		ctrl_t  ctrl;
	} uword_t;

	// Control store: wait for a transaction, scan the table, wait for the
	// output register to be free, then commit the result.
	function automatic uword_t ucode_rom(input upc_t pc);
		uword_t w;
		w = '0;
		case (pc)
			STEP_IDLE: begin
				w.jc        = JC_NO_TAKE;
				w.target    = STEP_IDLE;
				w.ctrl.idle = 1'b1;
			end
			STEP_SCAN: begin
				w.jc        = JC_SCAN_BUSY;
				w.target    = STEP_SCAN;
				w.ctrl.scan = 1'b1;
			end
			STEP_WAIT: begin
				w.jc     = JC_OUT_BUSY;
				w.target = STEP_WAIT;
			end
			STEP_COMMIT: begin
				w.jc          = JC_ALWAYS;
				w.target      = STEP_IDLE;
				w.ctrl.commit = 1'b1;
			end
			default: begin
				w.jc     = JC_ALWAYS;
				w.target = STEP_IDLE;
			end
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

>>> design/ket_ram.sv
// ----------------------------------------------------------------------------
// ket_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module ket_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

>>> design/ket_seq.sv
// ----------------------------------------------------------------------------
// ket_seq
// Microcode sequencer: a step counter over the control store with
// conditional jumps, issuing one control word per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ket_seq (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire ket_pkg::cond_t cond,
	output ket_pkg::ctrl_t      ctrl
);
	import ket_pkg::*;

	upc_t   pc_q;
	upc_t   pc_d;
	uword_t word;
	logic   jump;

	// Fetch the current control word.
	assign word = ucode_rom(pc_q);
	assign ctrl = word.ctrl;

	// Evaluate the jump condition and select the next step.
	always_comb begin
		case (word.jc)
			JC_ALWAYS:    jump = 1'b1;
			JC_NO_TAKE:   jump = !cond.in_valid;
			JC_SCAN_BUSY: jump = cond.scan_busy;
			JC_OUT_BUSY:  jump = cond.out_busy;
			default:      jump = 1'b1;
		endcase
		pc_d = jump ? word.target : upc_t'(pc_q + 1'b1);
	end

	// Step counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= STEP_IDLE;
		end else begin
			pc_q <= pc_d;
		end
	end

endmodule

`default_nettype wire

>>> design/key_entry_table_upsert.sv
// ----------------------------------------------------------------------------
// key_entry_table_upsert: when no id matches, the scan runs over the configured
// search limit (capped at 64 entries); an id match at entry k ends the scan.
// One transaction in flight: the next is accepted in the cycle after the result
// is loaded, and the result is held back while the output stalls.
// Reset clears the table at once via per-entry valid bits; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module key_entry_table_upsert (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire ket_pkg::in_item_t               in_data,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output ket_pkg::out_item_t                   out_data,
	input  wire logic                            cfg_we,
	input  wire logic [ket_pkg::CFG_W-1:0]       cfg_wdata
);
	import ket_pkg::*;

	ctrl_t ctrl;
	cond_t cond;

	logic [CFG_W-1:0]        cfg_q;
	logic [CNT_W-1:0]        lim;

	logic                    mode_q;
	logic [ID_BITS-1:0]      cid_q;
	logic [ID_BITS-1:0]      sid_q;
	logic [PAYLOAD_BITS-1:0] pay_q;

	logic [CNT_W-1:0]        rd_idx_q;
	logic                    cmp_v_s1;
	logic [IDX_W-1:0]        cmp_idx_s1;
	logic                    vld_s1;
	logic [TABLE_ENTRIES-1:0] valid_q;

	logic                    hit_q;
	logic [IDX_W-1:0]        hit_idx_q;
	logic [PAYLOAD_BITS-1:0] hit_pay_q;
	logic                    emp_q;
	logic [IDX_W-1:0]        emp_idx_q;

	logic [WORD_W-1:0]       rd_data;
	logic [ID_BITS-1:0]      ent_cid;
	logic [ID_BITS-1:0]      ent_sid;
	logic [PAYLOAD_BITS-1:0] ent_pay;
	logic                    id_match;
	logic                    empty_match;
	logic                    more;
	logic                    issue;

	logic                    mem_we;
	logic [IDX_W-1:0]        wr_pos;
	out_item_t               res;

	logic                    out_valid_q;
	out_item_t               out_q;

	// Microcode sequencer.
	ket_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.cond   (cond),
		.ctrl   (ctrl)
	);

	// Entry table storage: client id, server id and payload in one word.
	ket_ram #(
		.WIDTH (WORD_W),
		.DEPTH (TABLE_ENTRIES)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (wr_pos),
		.wdata ({cid_q, sid_q, pay_q}),
		.re    (issue),
		.raddr (rd_idx_q[IDX_W-1:0]),
		.rdata (rd_data)
	);

	// Search limit register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= ENTRIES_RESET;
		end else if (cfg_we) begin
			cfg_q <= cfg_wdata;
		end
	end

	// The search never runs past the end of the table.
	always_comb begin
		if (32'(cfg_q) > TABLE_ENTRIES) begin
			lim = CNT_W'(TABLE_ENTRIES);
		end else begin
			lim = CNT_W'(cfg_q);
		end
	end

	// Capture the accepted transaction.
	always_ff @(posedge clk) begin
		if (ctrl.idle && in_valid) begin
			mode_q <= in_data.mode;
			cid_q  <= in_data.client_id[ID_BITS-1:0];
			sid_q  <= in_data.server_id[ID_BITS-1:0];
			pay_q  <= in_data.key_payload[PAYLOAD_BITS-1:0];
		end
	end

	// Compare the entry read in the previous cycle; a never written entry
	// reads as all zeros.
	assign ent_cid     = vld_s1 ? rd_data[WORD_W-1 -: ID_BITS] : '0;
	assign ent_sid     = vld_s1 ? rd_data[PAYLOAD_BITS +: ID_BITS] : '0;
	assign ent_pay     = vld_s1 ? rd_data[PAYLOAD_BITS-1:0] : '0;
	assign id_match    = cmp_v_s1 && (ent_cid == cid_q) && (ent_sid == sid_q);
	assign empty_match = cmp_v_s1 && (ent_cid == '0) && (ent_sid == '0) &&
		(ent_pay == '0);
	assign more        = rd_idx_q < lim;
	assign issue       = ctrl.scan && more && !id_match;

	// Scan control: the read index and the found flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_idx_q <= '0;
			cmp_v_s1 <= 1'b0;
			hit_q    <= 1'b0;
			emp_q    <= 1'b0;
		end else if (ctrl.idle) begin
			rd_idx_q <= '0;
			cmp_v_s1 <= 1'b0;
			hit_q    <= 1'b0;
			emp_q    <= 1'b0;
		end else if (ctrl.scan) begin
			if (issue) begin
				rd_idx_q <= CNT_W'(rd_idx_q + 1'b1);
			end
			cmp_v_s1 <= issue;
			if (id_match) begin
				hit_q <= 1'b1;
			end
			if (empty_match) begin
				emp_q <= 1'b1;
			end
		end
	end

	// Scan data: the compared index and the first matches.
	always_ff @(posedge clk) begin
		if (ctrl.scan) begin
			cmp_idx_s1 <= rd_idx_q[IDX_W-1:0];
			vld_s1     <= valid_q[rd_idx_q[IDX_W-1:0]];
			if (id_match) begin
				hit_idx_q <= cmp_idx_s1;
				hit_pay_q <= ent_pay;
			end
			if (empty_match && !emp_q) begin
				emp_idx_q <= cmp_idx_s1;
			end
		end
	end

	// Per-entry valid bits stand in for clearing the table at reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (mem_we) begin
			valid_q[wr_pos] <= 1'b1;
		end
	end

	// Resolve the transaction into a result and a table write.
	always_comb begin
		wr_pos = hit_q ? hit_idx_q : emp_idx_q;
		mem_we = 1'b0;
		res    = '0;
		if (mode_q == MODE_WRITE) begin
			if (hit_q || emp_q) begin
				mem_we          = ctrl.commit;
				res.status      = ST_OK;
				res.entry_index = 6'(wr_pos);
			end else begin
				res.status = ST_FULL;
			end
		end else begin
			if (hit_q) begin
				res.status          = ST_OK;
				res.entry_index     = 6'(hit_idx_q);
				res.key_payload_out = 64'(hit_pay_q);
			end else begin
				res.status = ST_NOT_FOUND;
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.commit) begin
			out_q <= res;
		end
	end

	// Conditions for the sequencer.
	assign cond.in_valid  = in_valid;
	assign cond.scan_busy = !id_match && (more || cmp_v_s1);
	assign cond.out_busy  = out_valid_q && !out_ready;

	assign in_ready  = ctrl.idle;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

`default_nettype wire
